### src/hmd_pkg.sv
package hmd_pkg;

    localparam int DEF_MAX_SIZE  = 64;
    localparam int DEF_FRAC_BITS = 24;

    localparam logic [1:0] OP_MATRIX   = 2'd0;
    localparam logic [1:0] OP_POSITION = 2'd1;
    localparam logic [1:0] OP_MOMENTUM = 2'd2;
    localparam logic [1:0] OP_RUN      = 2'd3;

    localparam logic [1:0] REG_SIZE      = 2'd0;
    localparam logic [1:0] REG_STEPS     = 2'd1;
    localparam logic [1:0] REG_STEP_SIZE = 2'd2;

    localparam logic [6:0]  RST_SIZE      = 7'd64;
    localparam logic [19:0] RST_STEPS     = 20'd1000;
    localparam logic [30:0] RST_STEP_SIZE = 31'd335544;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_START,
        DP_A_RD,
        DP_A_MUL,
        DP_A_ACC,
        DP_A_WR,
        DP_U_RD,
        DP_U_MUL1,
        DP_U_P,
        DP_U_MUL2,
        DP_U_Q,
        DP_E_RD,
        DP_E_MUL1,
        DP_E_S,
        DP_E_MUL2,
        DP_E_KE,
        DP_E_PE,
        DP_E_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   row_first;
    } t_cmd;

    typedef struct packed {
        logic out_valid;
    } t_status;

endpackage

### src/hmd_ctrl.sv
module hmd_ctrl
    import hmd_pkg::*;
#(
    parameter int MAX_SIZE = DEF_MAX_SIZE
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic [1:0]                   i_opcode,
    output logic                         o_in_ready,
    input  logic [6:0]                   i_size,
    input  logic [19:0]                  i_steps,
    input  t_status                      i_status,
    output t_cmd                         o_cmd,
    output logic [$clog2(MAX_SIZE)-1:0]  o_n,
    output logic [$clog2(MAX_SIZE)-1:0]  o_j
);

    localparam int IW = $clog2(MAX_SIZE);
    localparam int NW = $clog2(MAX_SIZE + 1);

    typedef enum logic [16:0] {
        S_IDLE   = 17'b00000000000000001,
        S_A_RD   = 17'b00000000000000010,
        S_A_MUL  = 17'b00000000000000100,
        S_A_ACC  = 17'b00000000000001000,
        S_A_WR   = 17'b00000000000010000,
        S_U_RD   = 17'b00000000000100000,
        S_U_MUL1 = 17'b00000000001000000,
        S_U_P    = 17'b00000000010000000,
        S_U_MUL2 = 17'b00000000100000000,
        S_U_Q    = 17'b00000001000000000,
        S_E_RD   = 17'b00000010000000000,
        S_E_MUL1 = 17'b00000100000000000,
        S_E_S    = 17'b00001000000000000,
        S_E_MUL2 = 17'b00010000000000000,
        S_E_KE   = 17'b00100000000000000,
        S_E_PE   = 17'b01000000000000000,
        S_E_OUT  = 17'b10000000000000000
    } t_state;

    t_state          r_state, n_state;
    logic [IW-1:0]   r_n, n_n, r_j, n_j;
    logic [19:0]     r_c, n_c;
    logic            r_final, n_final;
    logic [NW-1:0]   r_nu, n_nu;
    logic [NW-1:0]   size_lim;
    logic [IW-1:0]   last;
    logic            accept;

    assign size_lim = (32'(i_size) > MAX_SIZE) ? NW'(MAX_SIZE) : NW'(i_size);
    assign last = IW'(r_nu - NW'(1));
    assign o_in_ready = (r_state == S_IDLE) && !(i_opcode == OP_RUN && i_status.out_valid);
    assign accept = i_in_valid && o_in_ready;
    assign o_n = r_n;
    assign o_j = r_j;

    always_comb begin
        n_state = r_state;
        n_n = r_n;
        n_j = r_j;
        n_c = r_c;
        n_final = r_final;
        n_nu = r_nu;
        o_cmd.op = DP_NOP;
        o_cmd.row_first = (r_j == '0);
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_opcode == OP_RUN) begin
                        o_cmd.op = DP_START;
                        n_nu = size_lim;
                        n_n = '0;
                        n_j = '0;
                        n_c = '0;
                        n_final = (i_steps == '0);
                        n_state = (size_lim == '0) ? S_E_OUT : S_A_RD;
                    end else begin
                        o_cmd.op = DP_LOAD;
                    end
                end
            end
            S_A_RD: begin
                o_cmd.op = DP_A_RD;
                n_state = S_A_MUL;
            end
            S_A_MUL: begin
                o_cmd.op = DP_A_MUL;
                n_state = S_A_ACC;
            end
            S_A_ACC: begin
                o_cmd.op = DP_A_ACC;
                if (r_j == last) begin
                    n_state = S_A_WR;
                end else begin
                    n_j = r_j + IW'(1);
                    n_state = S_A_RD;
                end
            end
            S_A_WR: begin
                o_cmd.op = DP_A_WR;
                n_j = '0;
                if (r_n == last) begin
                    n_n = '0;
                    n_state = r_final ? S_E_RD : S_U_RD;
                end else begin
                    n_n = r_n + IW'(1);
                    n_state = S_A_RD;
                end
            end
            S_U_RD: begin
                o_cmd.op = DP_U_RD;
                n_state = S_U_MUL1;
            end
            S_U_MUL1: begin
                o_cmd.op = DP_U_MUL1;
                n_state = S_U_P;
            end
            S_U_P: begin
                o_cmd.op = DP_U_P;
                n_state = S_U_MUL2;
            end
            S_U_MUL2: begin
                o_cmd.op = DP_U_MUL2;
                n_state = S_U_Q;
            end
            S_U_Q: begin
                o_cmd.op = DP_U_Q;
                if (r_n == last) begin
                    n_n = '0;
                    n_c = r_c + 20'd1;
                    n_final = ((r_c + 20'd1) == i_steps);
                    n_state = S_A_RD;
                end else begin
                    n_n = r_n + IW'(1);
                    n_state = S_U_RD;
                end
            end
            S_E_RD: begin
                o_cmd.op = DP_E_RD;
                n_state = S_E_MUL1;
            end
            S_E_MUL1: begin
                o_cmd.op = DP_E_MUL1;
                n_state = S_E_S;
            end
            S_E_S: begin
                o_cmd.op = DP_E_S;
                n_state = S_E_MUL2;
            end
            S_E_MUL2: begin
                o_cmd.op = DP_E_MUL2;
                n_state = S_E_KE;
            end
            S_E_KE: begin
                o_cmd.op = DP_E_KE;
                n_state = S_E_PE;
            end
            S_E_PE: begin
                o_cmd.op = DP_E_PE;
                if (r_n == last) begin
                    n_state = S_E_OUT;
                end else begin
                    n_n = r_n + IW'(1);
                    n_state = S_E_RD;
                end
            end
            S_E_OUT: begin
                o_cmd.op = DP_E_OUT;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n <= '0;
            r_j <= '0;
            r_c <= '0;
            r_final <= 1'b0;
            r_nu <= '0;
        end else begin
            r_state <= n_state;
            r_n <= n_n;
            r_j <= n_j;
            r_c <= n_c;
            r_final <= n_final;
            r_nu <= n_nu;
        end
    end

endmodule

### src/hmd_datapath.sv
module hmd_datapath
    import hmd_pkg::*;
#(
    parameter int MAX_SIZE  = DEF_MAX_SIZE,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    input  logic [$clog2(MAX_SIZE)-1:0]  i_n,
    input  logic [$clog2(MAX_SIZE)-1:0]  i_j,
    input  logic [1:0]                   i_opcode,
    input  logic [5:0]                   i_row,
    input  logic [5:0]                   i_column,
    input  logic signed [31:0]           i_value,
    input  logic [30:0]                  i_step_size,
    output t_status                      o_status,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [47:0]           o_kinetic_energy,
    output logic signed [47:0]           o_total_energy,
    output logic                         o_saturated
);

    localparam int IW = $clog2(MAX_SIZE);
    localparam int AW = $clog2(MAX_SIZE * MAX_SIZE);
    localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
    localparam logic signed [63:0] Q_MIN = -64'sd2147483648;
    localparam logic signed [63:0] E_MAX = 64'sd140737488355327;
    localparam logic signed [63:0] E_MIN = -64'sd140737488355328;

    function automatic logic [32:0] clamp_q(input logic signed [63:0] x);
        logic [32:0] r;
        if (x > Q_MAX) begin
            r = {1'b1, Q_MAX[31:0]};
        end else if (x < Q_MIN) begin
            r = {1'b1, Q_MIN[31:0]};
        end else begin
            r = {1'b0, x[31:0]};
        end
        return r;
    endfunction

    function automatic logic [48:0] clamp_e(input logic signed [63:0] x);
        logic [48:0] r;
        if (x > E_MAX) begin
            r = {1'b1, E_MAX[47:0]};
        end else if (x < E_MIN) begin
            r = {1'b1, E_MIN[47:0]};
        end else begin
            r = {1'b0, x[47:0]};
        end
        return r;
    endfunction

    logic signed [31:0] r_mat [MAX_SIZE*MAX_SIZE];
    logic signed [31:0] r_pos [MAX_SIZE];
    logic signed [31:0] r_mom [MAX_SIZE];
    logic signed [31:0] r_acl [MAX_SIZE];

    logic signed [31:0] r_m_rd, r_q_rd, r_p_rd, r_a_rd, r_pn, r_s;
    logic signed [63:0] r_prod, r_acc, r_ekin, r_epot;
    logic               r_sat, r_out_valid;
    logic signed [47:0] r_ke, r_te;
    logic               r_sat_out;

    logic               ld, ld_row_ok, ld_col_ok;
    logic [IW-1:0]      ld_row, ld_col, vidx;
    logic [AW-1:0]      mat_ra, mat_wa;
    logic signed [31:0] delta_s, mul_a, mul_b;
    logic signed [63:0] sh_f, sh_f1, etot;
    logic [32:0]        c_acc, c_pn, c_q, c_s;
    logic [48:0]        c_ke, c_te;
    logic               pos_we, mom_we;
    logic signed [31:0] pos_wd, mom_wd;

    assign ld = (i_cmd.op == DP_LOAD);
    assign ld_row_ok = (32'(i_row) < MAX_SIZE);
    assign ld_col_ok = (32'(i_column) < MAX_SIZE);
    assign ld_row = IW'(i_row);
    assign ld_col = IW'(i_column);
    assign mat_wa = AW'(ld_row) * AW'(MAX_SIZE) + AW'(ld_col);
    assign mat_ra = AW'(i_n) * AW'(MAX_SIZE) + AW'(i_j);
    assign vidx = (i_cmd.op == DP_A_RD) ? i_j : i_n;
    assign delta_s = $signed({1'b0, i_step_size});

    assign sh_f = r_prod >>> FRAC_BITS;
    assign sh_f1 = r_prod >>> (FRAC_BITS + 1);
    assign c_acc = clamp_q(r_acc);
    assign c_pn = clamp_q(64'(r_p_rd) - sh_f);
    assign c_q = clamp_q(64'(r_q_rd) + sh_f);
    assign c_s = clamp_q(64'(r_p_rd) - sh_f1);
    assign etot = r_ekin + r_epot;
    assign c_ke = clamp_e(r_ekin);
    assign c_te = clamp_e(etot);

    always_comb begin
        mul_a = delta_s;
        mul_b = r_a_rd;
        unique case (i_cmd.op)
            DP_A_MUL: begin
                mul_a = r_m_rd;
                mul_b = r_q_rd;
            end
            DP_U_MUL2: begin
                mul_b = r_pn;
            end
            DP_E_MUL2: begin
                mul_a = r_s;
                mul_b = r_s;
            end
            DP_E_KE: begin
                mul_a = r_q_rd;
            end
            default: begin
                mul_a = delta_s;
            end
        endcase
    end

    assign pos_we = (ld && i_opcode == OP_POSITION && ld_row_ok) || (i_cmd.op == DP_U_Q);
    assign pos_wd = (i_cmd.op == DP_U_Q) ? $signed(c_q[31:0]) : i_value;
    assign mom_we = (ld && i_opcode == OP_MOMENTUM && ld_row_ok) || (i_cmd.op == DP_U_P);
    assign mom_wd = (i_cmd.op == DP_U_P) ? $signed(c_pn[31:0]) : i_value;

    always_ff @(posedge i_clk) begin
        if (ld && i_opcode == OP_MATRIX && ld_row_ok && ld_col_ok) begin
            r_mat[mat_wa] <= i_value;
        end
        if (i_cmd.op == DP_A_RD) begin
            r_m_rd <= r_mat[mat_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            r_pos[(i_cmd.op == DP_U_Q) ? i_n : ld_row] <= pos_wd;
        end
        if (i_cmd.op == DP_A_RD || i_cmd.op == DP_U_RD || i_cmd.op == DP_E_RD) begin
            r_q_rd <= r_pos[vidx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mom_we) begin
            r_mom[(i_cmd.op == DP_U_P) ? i_n : ld_row] <= mom_wd;
        end
        if (i_cmd.op == DP_U_RD || i_cmd.op == DP_E_RD) begin
            r_p_rd <= r_mom[i_n];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_A_WR) begin
            r_acl[i_n] <= $signed(c_acc[31:0]);
        end
        if (i_cmd.op == DP_U_RD || i_cmd.op == DP_E_RD) begin
            r_a_rd <= r_acl[i_n];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (i_cmd.op == DP_A_ACC) begin
            r_acc <= (i_cmd.row_first ? 64'sd0 : r_acc) + sh_f;
        end
        if (i_cmd.op == DP_U_P) begin
            r_pn <= $signed(c_pn[31:0]);
        end
        if (i_cmd.op == DP_E_S) begin
            r_s <= $signed(c_s[31:0]);
        end
        if (i_cmd.op == DP_START) begin
            r_ekin <= '0;
            r_epot <= '0;
        end else if (i_cmd.op == DP_E_KE) begin
            r_ekin <= r_ekin + sh_f1;
        end else if (i_cmd.op == DP_E_PE) begin
            r_epot <= r_epot + sh_f1;
        end
        if (i_cmd.op == DP_E_OUT) begin
            r_ke <= $signed(c_ke[47:0]);
            r_te <= $signed(c_te[47:0]);
            r_sat_out <= r_sat | c_ke[48] | c_te[48];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            priority case (1'b1)
                i_cmd.op == DP_START: r_sat <= 1'b0;
                i_cmd.op == DP_A_WR:  r_sat <= r_sat | c_acc[32];
                i_cmd.op == DP_U_P:   r_sat <= r_sat | c_pn[32];
                i_cmd.op == DP_U_Q:   r_sat <= r_sat | c_q[32];
                i_cmd.op == DP_E_S:   r_sat <= r_sat | c_s[32];
                default:              r_sat <= r_sat;
            endcase
            if (i_cmd.op == DP_E_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_valid = r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_kinetic_energy = r_ke;
    assign o_total_energy = r_te;
    assign o_saturated = r_sat_out;

endmodule

### src/harmonic_md_trajectory_core.sv
// Harmonic trajectory core. Load items (matrix entry, position, momentum) give no result.
// A run item with N = min(size_in_use, MAX_SIZE) coordinates and S steps occupies the
// core, its pace set by one shared 32x32 multiplier and single-port matrix and vector
// memories; each matrix-vector multiply-accumulate reads, multiplies, then accumulates.
// The result sits in an output register; loads are taken while it waits, a new run waits
// until it has been transferred. Matrix, position and momentum entries read undefined
// until written.
module harmonic_md_trajectory_core
    import hmd_pkg::*;
#(
    parameter int MAX_SIZE  = DEF_MAX_SIZE,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [30:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_opcode,
    input  logic [5:0]         i_row,
    input  logic [5:0]         i_column,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [47:0] o_kinetic_energy,
    output logic signed [47:0] o_total_energy,
    output logic               o_saturated
);

    localparam int IW = $clog2(MAX_SIZE);

    logic [6:0]    r_size;
    logic [19:0]   r_steps;
    logic [30:0]   r_step_size;
    t_cmd          cmd;
    t_status       status;
    logic [IW-1:0] n_idx, j_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= RST_SIZE;
            r_steps <= RST_STEPS;
            r_step_size <= RST_STEP_SIZE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SIZE:      r_size <= i_cfg_data[6:0];
                REG_STEPS:     r_steps <= i_cfg_data[19:0];
                REG_STEP_SIZE: r_step_size <= i_cfg_data;
                default:       r_size <= r_size;
            endcase
        end
    end

    hmd_ctrl #(
        .MAX_SIZE(MAX_SIZE)
    ) u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .i_opcode(i_opcode),
        .o_in_ready(o_in_ready),
        .i_size(r_size),
        .i_steps(r_steps),
        .i_status(status),
        .o_cmd(cmd),
        .o_n(n_idx),
        .o_j(j_idx)
    );

    hmd_datapath #(
        .MAX_SIZE(MAX_SIZE),
        .FRAC_BITS(FRAC_BITS)
    ) u_datapath (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd(cmd),
        .i_n(n_idx),
        .i_j(j_idx),
        .i_opcode(i_opcode),
        .i_row(i_row),
        .i_column(i_column),
        .i_value(i_value),
        .i_step_size(r_step_size),
        .o_status(status),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_kinetic_energy(o_kinetic_energy),
        .o_total_energy(o_total_energy),
        .o_saturated(o_saturated)
    );

endmodule

### src/hmd_checker.sv
module hmd_checker
    import hmd_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic [1:0]         i_opcode,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [47:0] o_kinetic_energy
);

    logic run_xfer;
    assign run_xfer = i_in_valid && o_in_ready && (i_opcode == OP_RUN);

    // result holds until transferred
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kinetic_energy))
        else $error("result dropped or changed while stalled");

    assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a run never overwrites a waiting result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        run_xfer |-> !o_out_valid)
        else $error("run taken while result pending");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        run_xfer |=> !o_in_ready && !o_out_valid)
        else $error("core not busy after run transfer");

endmodule

bind harmonic_md_trajectory_core hmd_checker u_hmd_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_valid(i_in_valid),
    .o_in_ready(o_in_ready),
    .i_opcode(i_opcode),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_kinetic_energy(o_kinetic_energy)
);
